// ===== rtl/core/crpe_pkg.sv =====
// Shared constants and types for the Catmull-Rom point evaluator.
// Used by catmull_rom_point_eval; no dependencies.
package crpe_pkg;

	localparam int MAX_POINTS = 64;
	localparam int FRAC_BITS  = 8;
	localparam int AW         = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int POS_W      = 14;
	localparam int SEG_W      = POS_W - FRAC_BITS;
	localparam int POINT_W    = 16;
	localparam int U_W        = FRAC_BITS + 1;
	localparam int PW         = POINT_W + 2;
	localparam int HW         = POINT_W + 6;
	localparam int PRW        = HW + U_W + 1;
	localparam int TAPS       = 4;
	localparam int AXES       = 2;
	localparam int ENTRY_W    = 2 * POINT_W;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 2 * POINT_W;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
	localparam logic [U_W-1:0]   U_ONE   = U_W'(1 << FRAC_BITS);

	localparam logic signed [PRW-1:0] RND_HALF = PRW'(1 << (FRAC_BITS - 1));
	localparam logic signed [HW-1:0]  SAT_HI   = HW'((1 << (POINT_W - 1)) - 1);
	localparam logic signed [HW-1:0]  SAT_LO   = -HW'(1 << (POINT_W - 1));

	typedef logic signed [PW-1:0]  point_t;
	typedef logic signed [HW-1:0]  coef_t;
	typedef logic signed [PRW-1:0] prod_t;

endpackage

// ===== rtl/core/crpe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module crpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/catmull_rom_point_eval.sv =====
// Top level of the uniform Catmull-Rom point evaluator.
// Depends on crpe_pkg and crpe_ram.
//
// Write transactions (tuser = 0) store one control point; evaluate transactions
// (tuser = 1) return one curve point. When the output is not stalled, the block
// takes one transaction per cycle and delivers one result per cycle. The point
// table is held in four identical RAM copies, written together, so the four
// neighbors of a segment are read in a single cycle; a write is seen by every
// evaluate accepted in a later cycle. The table is not cleared at reset, so
// points must be written before a segment using them is evaluated. The user
// must write point_count only while no evaluate is in flight; the block itself
// does not enforce this.
module catmull_rom_point_eval (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// point_index[5:0], point_x[21:6], point_y[37:22], position[51:38], zero pad
	input  logic [crpe_pkg::S_TDATA_W-1:0]     s_tdata,
	// cmd[0]
	input  logic [0:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// out_x[15:0], out_y[31:16]
	output logic [crpe_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [crpe_pkg::CNT_W-1:0]         cfg_data
);

	localparam int AW    = crpe_pkg::AW;
	localparam int CNT_W = crpe_pkg::CNT_W;
	localparam int U_W   = crpe_pkg::U_W;
	localparam int PW    = crpe_pkg::PW;
	localparam int HW    = crpe_pkg::HW;
	localparam int PRW   = crpe_pkg::PRW;
	localparam int PTW   = crpe_pkg::POINT_W;
	localparam int FB    = crpe_pkg::FRAC_BITS;
	localparam int SEGW  = crpe_pkg::SEG_W;
	localparam int TAPS  = crpe_pkg::TAPS;
	localparam int AXES  = crpe_pkg::AXES;

	logic [CNT_W-1:0] point_count_q;

	logic                       in_cmd;
	logic [AW-1:0]              in_index;
	logic [PTW-1:0]             in_x;
	logic [PTW-1:0]             in_y;
	logic [crpe_pkg::POS_W-1:0] in_pos;
	logic                       in_acc;
	logic                       wr_en;

	logic [CNT_W-1:0] n_eff;
	logic [SEGW-1:0]  seg;
	logic             past_end;
	logic [AW-1:0]    k;
	logic [U_W-1:0]   u_in;
	logic             first_in;
	logic             last_in;
	logic [AW-1:0]    raddr [TAPS];
	logic [crpe_pkg::ENTRY_W-1:0] rdata [TAPS];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7, adv_s8, adv_s9;
	logic adv_out;

	logic [U_W-1:0] u_s1, u_s2, u_s3, u_s4, u_s5, u_s6, u_s7;
	logic           first_s1, last_s1;

	crpe_pkg::point_t p_s2 [AXES][TAPS];
	crpe_pkg::coef_t  a_s3 [AXES], b_s3 [AXES], c_s3 [AXES], d_s3 [AXES];
	crpe_pkg::prod_t  prod_s4 [AXES];
	crpe_pkg::coef_t  a_s4 [AXES], b_s4 [AXES], c_s4 [AXES];
	crpe_pkg::coef_t  h1_s5 [AXES], a_s5 [AXES], b_s5 [AXES];
	crpe_pkg::prod_t  prod_s6 [AXES];
	crpe_pkg::coef_t  a_s6 [AXES], b_s6 [AXES];
	crpe_pkg::coef_t  h2_s7 [AXES], a_s7 [AXES];
	crpe_pkg::prod_t  prod_s8 [AXES];
	crpe_pkg::coef_t  a_s8 [AXES];
	crpe_pkg::coef_t  h3_s9 [AXES];
	logic [PTW-1:0]   res_q [AXES];

	crpe_pkg::point_t p_raw [AXES][TAPS];
	crpe_pkg::point_t p_ext [AXES][TAPS];
	crpe_pkg::coef_t  pe [AXES][TAPS];
	crpe_pkg::coef_t  a_c [AXES], b_c [AXES], c_c [AXES], d_c [AXES];
	crpe_pkg::coef_t  h1_c [AXES], h2_c [AXES], h3_c [AXES];
	crpe_pkg::prod_t  pd_c [AXES], p1_c [AXES], p2_c [AXES];
	crpe_pkg::coef_t  half_c [AXES];
	logic [PTW-1:0]   sat_c [AXES];

	assign in_cmd   = s_tuser[0];
	assign in_index = s_tdata[AW-1:0];
	assign in_x     = s_tdata[6 +: PTW];
	assign in_y     = s_tdata[22 +: PTW];
	assign in_pos   = s_tdata[38 +: crpe_pkg::POS_W];
	assign in_acc   = s_tvalid && s_tready;
	assign wr_en    = in_acc && (in_cmd == crpe_pkg::CMD_WRITE);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= crpe_pkg::CNT_MIN;
		end else if (cfg_valid) begin
			point_count_q <= cfg_data;
		end
	end

	// segment select and neighbor addresses
	always_comb begin
		priority if (point_count_q < crpe_pkg::CNT_MIN) begin
			n_eff = crpe_pkg::CNT_MIN;
		end else if (point_count_q > crpe_pkg::CNT_MAX) begin
			n_eff = crpe_pkg::CNT_MAX;
		end else begin
			n_eff = point_count_q;
		end
		seg      = in_pos[crpe_pkg::POS_W-1:FB];
		past_end = CNT_W'(seg) >= (n_eff - CNT_W'(1));
		if (past_end) begin
			k    = AW'(n_eff - CNT_W'(2));
			u_in = crpe_pkg::U_ONE;
		end else begin
			k    = AW'(seg);
			u_in = U_W'(in_pos[FB-1:0]);
		end
		first_in = (k == '0);
		last_in  = (CNT_W'(k) + CNT_W'(2)) >= n_eff;
		for (int j = 0; j < TAPS; j++) begin
			raddr[j] = k + AW'(j) - AW'(1);
		end
	end

	for (genvar j = 0; j < TAPS; j++) begin : g_tap
		crpe_ram #(
			.WIDTH(crpe_pkg::ENTRY_W),
			.DEPTH(crpe_pkg::MAX_POINTS)
		) u_ram (
			.clk  (clk),
			.we   (wr_en),
			.waddr(in_index),
			.wdata({in_y, in_x}),
			.re   (adv_s1),
			.raddr(raddr[j]),
			.rdata(rdata[j])
		);
	end

	// stall chain: a stage loads when empty or when it drains
	assign adv_out  = !m_tvalid || m_tready;
	assign adv_s9   = !v_s9 || adv_out;
	assign adv_s8   = !v_s8 || adv_s9;
	assign adv_s7   = !v_s7 || adv_s8;
	assign adv_s6   = !v_s6 || adv_s7;
	assign adv_s5   = !v_s5 || adv_s6;
	assign adv_s4   = !v_s4 || adv_s5;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_comb begin
		for (int ax = 0; ax < AXES; ax++) begin
			for (int j = 0; j < TAPS; j++) begin
				p_raw[ax][j] = PW'($signed(rdata[j][ax*PTW +: PTW]));
			end
			p_ext[ax][0] = first_s1 ? ((p_raw[ax][1] <<< 1) - p_raw[ax][2]) : p_raw[ax][0];
			p_ext[ax][1] = p_raw[ax][1];
			p_ext[ax][2] = p_raw[ax][2];
			p_ext[ax][3] = last_s1 ? ((p_raw[ax][2] <<< 1) - p_raw[ax][1]) : p_raw[ax][3];

			for (int j = 0; j < TAPS; j++) begin
				pe[ax][j] = HW'(p_s2[ax][j]);
			end
			a_c[ax] = pe[ax][1] <<< 1;
			b_c[ax] = pe[ax][2] - pe[ax][0];
			c_c[ax] = (pe[ax][0] <<< 1) - ((pe[ax][1] <<< 2) + pe[ax][1])
				+ (pe[ax][2] <<< 2) - pe[ax][3];
			d_c[ax] = -pe[ax][0] + ((pe[ax][1] <<< 1) + pe[ax][1])
				- ((pe[ax][2] <<< 1) + pe[ax][2]) + pe[ax][3];

			pd_c[ax] = PRW'(d_s3[ax]) * PRW'($signed({1'b0, u_s3}));
			h1_c[ax] = c_s4[ax] + HW'((prod_s4[ax] + crpe_pkg::RND_HALF) >>> FB);
			p1_c[ax] = PRW'(h1_s5[ax]) * PRW'($signed({1'b0, u_s5}));
			h2_c[ax] = b_s6[ax] + HW'((prod_s6[ax] + crpe_pkg::RND_HALF) >>> FB);
			p2_c[ax] = PRW'(h2_s7[ax]) * PRW'($signed({1'b0, u_s7}));
			h3_c[ax] = a_s8[ax] + HW'((prod_s8[ax] + crpe_pkg::RND_HALF) >>> FB);

			half_c[ax] = (h3_s9[ax] + HW'(1)) >>> 1;
			priority if (half_c[ax] > crpe_pkg::SAT_HI) begin
				sat_c[ax] = PTW'(crpe_pkg::SAT_HI);
			end else if (half_c[ax] < crpe_pkg::SAT_LO) begin
				sat_c[ax] = PTW'(crpe_pkg::SAT_LO);
			end else begin
				sat_c[ax] = half_c[ax][PTW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_acc && (in_cmd == crpe_pkg::CMD_EVAL);
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
			if (adv_s7) v_s7 <= v_s6;
			if (adv_s8) v_s8 <= v_s7;
			if (adv_s9) v_s9 <= v_s8;
			if (adv_out) m_tvalid <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			u_s1     <= u_in;
			first_s1 <= first_in;
			last_s1  <= last_in;
		end
		if (adv_s2) begin
			u_s2 <= u_s1;
			p_s2 <= p_ext;
		end
		if (adv_s3) begin
			u_s3 <= u_s2;
			a_s3 <= a_c;
			b_s3 <= b_c;
			c_s3 <= c_c;
			d_s3 <= d_c;
		end
		if (adv_s4) begin
			u_s4    <= u_s3;
			prod_s4 <= pd_c;
			a_s4    <= a_s3;
			b_s4    <= b_s3;
			c_s4    <= c_s3;
		end
		if (adv_s5) begin
			u_s5  <= u_s4;
			h1_s5 <= h1_c;
			a_s5  <= a_s4;
			b_s5  <= b_s4;
		end
		if (adv_s6) begin
			u_s6    <= u_s5;
			prod_s6 <= p1_c;
			a_s6    <= a_s5;
			b_s6    <= b_s5;
		end
		if (adv_s7) begin
			u_s7  <= u_s6;
			h2_s7 <= h2_c;
			a_s7  <= a_s6;
		end
		if (adv_s8) begin
			prod_s8 <= p2_c;
			a_s8    <= a_s7;
		end
		if (adv_s9) begin
			h3_s9 <= h3_c;
		end
		if (adv_out) begin
			res_q <= sat_c;
		end
	end

	assign m_tdata = {res_q[1], res_q[0]};

endmodule
